@@ rtl/optical_ook_link_transceiver_top_assert.svh @@
// Assertion macros shared by the transceiver RTL.
// Both macros sample on clock and are disabled while reset is high.
`ifndef OPTICAL_OOK_LINK_TRANSCEIVER_TOP_ASSERT_SVH
`define OPTICAL_OOK_LINK_TRANSCEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define OOKLT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OOKLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/ooklt_pkg.sv @@
package ooklt_pkg;

   // frame and timing constants
   localparam int unsigned FRAME_BITS      = 12;
   localparam int unsigned BIT_PERIOD      = 64;
   localparam int unsigned SAMPLE_INTERVAL = 8;
   localparam int unsigned MSG_BITS        = 4;
   localparam logic [MSG_BITS-1:0] MSG_MASK = 4'hF;

   localparam int unsigned TICK_PERIOD = BIT_PERIOD * SAMPLE_INTERVAL;
   localparam int unsigned TICK_W      = $clog2(TICK_PERIOD);
   localparam int unsigned PHASE_W     = $clog2(BIT_PERIOD);
   localparam int unsigned TX_IDX_W    = $clog2(FRAME_BITS);
   localparam int unsigned MSG_IDX_W   = $clog2(MSG_BITS);
   localparam int unsigned FRAME_LEAD  = FRAME_BITS - MSG_BITS - 1;

   // field widths
   localparam int unsigned ELAPSED_W   = 9;
   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned DRIVE_W     = 8;
   localparam int unsigned RXMSG_W     = 5;
   localparam int unsigned DARK_W      = 16;
   localparam int unsigned RXCNT_W     = 3;
   localparam int unsigned SUM_W       = ((TICK_W > ELAPSED_W) ? TICK_W : ELAPSED_W) + 1;

   localparam logic [DARK_W-1:0] DARK_MAX    = '1;
   localparam logic [DARK_W-1:0] DARK_RELOAD =
      (BIT_PERIOD > 65535) ? 16'hFFFF : DARK_W'(BIT_PERIOD);

   // configuration port
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MESSAGE           = 8'd0,
      CSR_DARK_THRESHOLD    = 8'd1,
      CSR_PREAMBLE_MIN_TIME = 8'd2,
      CSR_DRIVE_FULL_SCALE  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [MSG_BITS-1:0] message;
      logic [SAMPLE_W-1:0] dark_threshold;
      logic [DARK_W-1:0]   preamble_min_time;
      logic [DRIVE_W-1:0]  drive_full_scale;
   } cfg_type;

   // per-transaction timing info handed to tx and rx
   typedef struct packed {
      logic               advance;
      logic               bit_boundary;
      logic               sample_time;
      logic [PHASE_W-1:0] phase;
   } step_type;

   typedef struct packed {
      logic               update;
      logic [DRIVE_W-1:0] level;
   } tx_out_type;

   // frame: ones, a zero, message LSB first, then a trailing zero
   function automatic logic frame_bit(input logic [TX_IDX_W-1:0] idx,
                                      input logic [MSG_BITS-1:0] msg);
      int unsigned pos;
      logic        bit_val;
      pos = 32'(idx);
      if (pos + 1 < FRAME_LEAD) begin
         bit_val = 1'b1;
      end else if (pos + 1 == FRAME_LEAD) begin
         bit_val = 1'b0;
      end else if (pos < FRAME_LEAD + MSG_BITS) begin
         bit_val = msg[MSG_IDX_W'(pos - FRAME_LEAD)];
      end else begin
         bit_val = 1'b0;
      end
      return bit_val;
   endfunction

endpackage

@@ rtl/ooklt_if.sv @@
interface ooklt_req_if;
   import ooklt_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [ELAPSED_W-1:0] elapsed_ms;
   logic [SAMPLE_W-1:0]  light_sample;
   modport source (output valid, output elapsed_ms, output light_sample, input ready);
   modport sink   (input valid, input elapsed_ms, input light_sample, output ready);
endinterface

interface ooklt_rsp_if;
   import ooklt_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      drive_update;
   logic [DRIVE_W-1:0]        drive_level;
   logic signed [RXMSG_W-1:0] received_message;
   modport source (output valid, output drive_update, output drive_level,
                   output received_message, input ready);
   modport sink   (input valid, input drive_update, input drive_level,
                   input received_message, output ready);
endinterface

interface ooklt_csr_if;
   import ooklt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ooklt_csr.sv @@
module ooklt_csr (
   input  logic             clock,
   input  logic             reset,
   ooklt_csr_if.sink        csr_bus,
   output ooklt_pkg::cfg_type cfg
);
   import ooklt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    write;

   assign csr_bus.ready = 1'b1;
   assign write = csr_bus.valid & csr_bus.ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (write) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_MESSAGE:           cfg_in.message           = csr_bus.data[MSG_BITS-1:0];
            CSR_DARK_THRESHOLD:    cfg_in.dark_threshold    = csr_bus.data[SAMPLE_W-1:0];
            CSR_PREAMBLE_MIN_TIME: cfg_in.preamble_min_time = csr_bus.data[DARK_W-1:0];
            CSR_DRIVE_FULL_SCALE:  cfg_in.drive_full_scale  = csr_bus.data[DRIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.message           <= '0;
         cfg_ff.dark_threshold    <= SAMPLE_W'(512);
         cfg_ff.preamble_min_time <= DARK_W'(320);
         cfg_ff.drive_full_scale  <= DRIVE_W'(255);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/ooklt_tx.sv @@
module ooklt_tx (
   input  logic                  clock,
   input  logic                  reset,
   input  ooklt_pkg::step_type   step,
   input  ooklt_pkg::cfg_type    cfg,
   output ooklt_pkg::tx_out_type tx_out
);
   import ooklt_pkg::*;

   logic [TX_IDX_W-1:0] idx_ff;
   logic [TX_IDX_W-1:0] idx_in;
   logic                cur_bit;

   assign cur_bit = frame_bit(idx_ff, cfg.message & MSG_MASK);

   always_comb begin
      idx_in = idx_ff;
      if (step.advance && step.bit_boundary) begin
         idx_in = (idx_ff == TX_IDX_W'(FRAME_BITS - 1)) ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

   assign tx_out.update = step.bit_boundary;
   assign tx_out.level  = (step.bit_boundary && cur_bit) ? cfg.drive_full_scale : '0;

endmodule

@@ rtl/ooklt_rx.sv @@
`include "optical_ook_link_transceiver_top_assert.svh"

module ooklt_rx (
   input  logic                       clock,
   input  logic                       reset,
   input  ooklt_pkg::step_type        step,
   input  ooklt_pkg::cfg_type         cfg,
   input  logic [ooklt_pkg::SAMPLE_W-1:0] light_sample,
   output logic signed [ooklt_pkg::RXMSG_W-1:0] msg_next
);
   import ooklt_pkg::*;

   logic                      in_data_ff,  in_data_in;
   logic [DARK_W-1:0]         dark_ff,     dark_in;
   logic [RXCNT_W-1:0]        count_ff,    count_in;
   logic [PHASE_W-1:0]        phase_ff,    phase_in;
   logic [MSG_BITS-1:0]       bits_ff,     bits_in;
   logic signed [RXMSG_W-1:0] last_ff,     last_in;

   logic              dark;
   logic [DARK_W:0]   dark_sum;

   assign dark     = light_sample < cfg.dark_threshold;
   assign dark_sum = {1'b0, dark_ff} + (DARK_W + 1)'(SAMPLE_INTERVAL);

   always_comb begin
      in_data_in = in_data_ff;
      dark_in    = dark_ff;
      count_in   = count_ff;
      phase_in   = phase_ff;
      bits_in    = bits_ff;
      last_in    = last_ff;
      if (step.advance) begin
         if (!in_data_ff) begin
            if (step.sample_time) begin
               if (dark) begin
                  dark_in = dark_sum[DARK_W] ? DARK_MAX : dark_sum[DARK_W-1:0];
               end else begin
                  // light ends the preamble; too short means a lost frame
                  if (dark_ff >= cfg.preamble_min_time) begin
                     in_data_in = 1'b1;
                  end else begin
                     last_in = '1;
                  end
                  dark_in  = '0;
                  phase_in = step.phase;
               end
            end
         end else if (step.phase == phase_ff) begin
            priority if (count_ff < RXCNT_W'(MSG_BITS)) begin
               bits_in[count_ff[MSG_IDX_W-1:0]] = dark;
               count_in = count_ff + 1'b1;
            end else if (count_ff == RXCNT_W'(MSG_BITS)) begin
               if (dark) begin
                  last_in    = '1;
                  count_in   = '0;
                  in_data_in = 1'b0;
                  dark_in    = '0;
               end else begin
                  count_in = count_ff + 1'b1;
               end
            end else if (count_ff == RXCNT_W'(MSG_BITS + 1)) begin
               // stop slot: must be dark
               count_in   = '0;
               in_data_in = 1'b0;
               dark_in    = DARK_RELOAD;
               last_in    = dark ? $signed({1'b0, bits_ff}) : '1;
            end else begin
               count_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_data_ff <= 1'b0;
         dark_ff    <= '0;
         count_ff   <= '0;
         phase_ff   <= '0;
         bits_ff    <= '0;
         last_ff    <= '1;
      end else begin
         in_data_ff <= in_data_in;
         dark_ff    <= dark_in;
         count_ff   <= count_in;
         phase_ff   <= phase_in;
         bits_ff    <= bits_in;
         last_ff    <= last_in;
      end
   end

   assign msg_next = last_in;

   `OOKLT_ASSERT_IMPL(a_rx_count_range, 1'b1, count_ff <= RXCNT_W'(MSG_BITS + 1), "rx bit count out of range")
   `OOKLT_ASSERT_IMPL(a_rx_idle_count, !in_data_ff, count_ff == '0, "rx bit count nonzero while waiting")
   `OOKLT_ASSERT_IMPL(a_rx_msg_range, last_ff[RXMSG_W-1], last_ff == '1, "rx message negative but not minus one")

endmodule

@@ rtl/optical_ook_link_transceiver_top.sv @@
// Channel   Dir  Handshake     Payload
// req_bus   in   valid/ready   elapsed_ms[8:0], light_sample[9:0]
// rsp_bus   out  valid/ready   drive_update, drive_level[7:0], received_message[4:0] signed
// csr_bus   in   valid/ready   index[7:0], data[15:0] (ready always high)
//
// One transaction per cycle sustained while rsp_bus.ready is high.
// Input register feeds tick/tx/rx update logic, result lands in the output register.
// req_bus.ready drops only when both stages are full and rsp_bus.ready is low.
// Reset is synchronous active high: tick, tx index and rx state cleared, message -1.
`include "optical_ook_link_transceiver_top_assert.svh"

module optical_ook_link_transceiver_top (
   input logic        clock,
   input logic        reset,
   ooklt_req_if.sink   req_bus,
   ooklt_rsp_if.source rsp_bus,
   ooklt_csr_if.sink   csr_bus
);
   import ooklt_pkg::*;

   cfg_type    cfg;
   step_type   step;
   tx_out_type tx_out;
   logic signed [RXMSG_W-1:0] msg_next;

   logic                 s1_valid_ff, s1_valid_in;
   logic [ELAPSED_W-1:0] s1_elapsed_ff;
   logic [SAMPLE_W-1:0]  s1_light_ff;

   logic [TICK_W-1:0] tick_ff, tick_in, tick_new;
   logic [SUM_W-1:0]  tick_sum;

   logic                      out_valid_ff, out_valid_in;
   logic                      out_update_ff;
   logic [DRIVE_W-1:0]        out_level_ff;
   logic signed [RXMSG_W-1:0] out_msg_ff;

   logic req_take;

   ooklt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   // wrapped tick; sum stays below twice the wrap period
   assign tick_sum = SUM_W'(tick_ff) + SUM_W'(s1_elapsed_ff);
   assign tick_new = (tick_sum >= SUM_W'(TICK_PERIOD)) ?
                     TICK_W'(tick_sum - SUM_W'(TICK_PERIOD)) : TICK_W'(tick_sum);

   assign step.advance      = s1_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign step.phase        = PHASE_W'(tick_new % TICK_W'(BIT_PERIOD));
   assign step.bit_boundary = (tick_new % TICK_W'(BIT_PERIOD)) == '0;
   assign step.sample_time  = (tick_new % TICK_W'(SAMPLE_INTERVAL)) == '0;

   ooklt_tx u_tx (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .cfg    (cfg),
      .tx_out (tx_out)
   );

   ooklt_rx u_rx (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .cfg          (cfg),
      .light_sample (s1_light_ff),
      .msg_next     (msg_next)
   );

   assign req_bus.ready = !s1_valid_ff || step.advance;
   assign req_take      = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step.advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step.advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      tick_in = step.advance ? tick_new : tick_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         tick_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         tick_ff      <= tick_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_elapsed_ff <= req_bus.elapsed_ms;
         s1_light_ff   <= req_bus.light_sample;
      end
      if (step.advance) begin
         out_update_ff <= tx_out.update;
         out_level_ff  <= tx_out.level;
         out_msg_ff    <= msg_next;
      end
   end

   assign rsp_bus.valid            = out_valid_ff;
   assign rsp_bus.drive_update     = out_update_ff;
   assign rsp_bus.drive_level      = out_level_ff;
   assign rsp_bus.received_message = out_msg_ff;

   `OOKLT_ASSERT_NEXT(a_adv_fills_out, step.advance, out_valid_ff, "result not registered")
   `OOKLT_ASSERT_IMPL(a_ready_when_empty, !s1_valid_ff, req_bus.ready, "empty but not ready")
   `OOKLT_ASSERT_IMPL(a_level_idle_zero, out_valid_ff && !out_update_ff, out_level_ff == '0, "idle level")
   `OOKLT_ASSERT_IMPL(a_tick_range, 1'b1, tick_ff <= TICK_W'(TICK_PERIOD - 1), "tick out of range")

endmodule
